/* design/wiag_pkg.sv */
package wiag_pkg;

   // CSR port geometry: four 64-bit registers at byte addresses 0, 8, 16, 24
   localparam int unsigned CSR_ADDR_BITS = 5;
   localparam int unsigned CSR_DATA_BITS = 64;
   localparam int unsigned CFG_BITS      = 64;
   localparam int unsigned NUM_DIMS_BITS = 3;
   localparam logic [NUM_DIMS_BITS-1:0] NUM_DIMS_RESET = 3'd2;

   // Register index, taken from paddr[4:3]
   typedef enum logic [1:0] {
      REG_NUM_DIMS      = 2'd0,
      REG_DEST_EXTENTS  = 2'd1,
      REG_SRC_EXTENTS   = 2'd2,
      REG_INSERT_ORIGIN = 2'd3
   } reg_index_type;

   // Setup sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_STRIDE = 3'b010,
      ST_ACCUM  = 3'b100
   } setup_state_type;

   // Setup status seen by the index walker and the top level
   typedef struct packed {
      logic busy;   // tables not ready, hold off transfers
      logic load;   // restart the walk at the base address
      logic oob;    // window exceeds the destination in a used dimension
      logic empty;  // a used source extent is zero
   } setup_status_type;

endpackage

/* design/wiag_setup.sv */
module wiag_setup #(
   parameter int unsigned MAX_DIMS    = 4,
   parameter int unsigned EXTENT_BITS = 16,
   parameter int unsigned ADDR_BITS   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           used     [MAX_DIMS],
   input  logic [EXTENT_BITS-1:0]         dest_ext [MAX_DIMS],
   input  logic [EXTENT_BITS-1:0]         src_ext  [MAX_DIMS],
   input  logic [EXTENT_BITS-1:0]         origin   [MAX_DIMS],
   output wiag_pkg::setup_status_type     status,
   output logic [ADDR_BITS-1:0]           base_addr,
   output logic [ADDR_BITS-1:0]           delta    [MAX_DIMS]
);

   localparam int unsigned DIM_IDX_BITS = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam logic [DIM_IDX_BITS-1:0] LAST_DIM = DIM_IDX_BITS'(MAX_DIMS - 1);

   wiag_pkg::setup_state_type state_ff, state_in;
   logic [DIM_IDX_BITS-1:0]   dim_ff, dim_in;
   logic                      load_ff, load_in;
   logic [ADDR_BITS-1:0]      stride_ff, stride_in;
   logic [EXTENT_BITS-1:0]    prev_de_ff, prev_de_in;
   logic [ADDR_BITS-1:0]      base_ff, base_in;
   logic [ADDR_BITS-1:0]      wrap_ff, wrap_in;
   logic [ADDR_BITS-1:0]      delta_ff [MAX_DIMS];
   logic [ADDR_BITS-1:0]      delta_in;
   logic                      oob_ff, oob_in;
   logic                      empty_ff, empty_in;

   logic [EXTENT_BITS-1:0]    se_cur;
   logic [EXTENT_BITS-1:0]    se_m1;
   logic [EXTENT_BITS:0]      reach;
   logic [ADDR_BITS-1:0]      origin_term;
   logic [ADDR_BITS-1:0]      wrap_term;

   // Stride step multiplies in the previous extent; accumulate step adds origin and wrap terms
   always_comb begin
      se_cur      = src_ext[dim_ff];
      se_m1       = se_cur - EXTENT_BITS'(1);
      reach       = {1'b0, origin[dim_ff]} + {1'b0, se_cur};
      origin_term = ADDR_BITS'(origin[dim_ff]) * stride_ff;
      wrap_term   = ADDR_BITS'(se_m1) * stride_ff;

      state_in   = state_ff;
      dim_in     = dim_ff;
      load_in    = 1'b0;
      stride_in  = stride_ff;
      prev_de_in = prev_de_ff;
      base_in    = base_ff;
      wrap_in    = wrap_ff;
      delta_in   = stride_ff - wrap_ff;
      oob_in     = oob_ff;
      empty_in   = empty_ff;

      case (state_ff)
         wiag_pkg::ST_IDLE: begin
            state_in = wiag_pkg::ST_IDLE;
         end
         wiag_pkg::ST_STRIDE: begin
            if (dim_ff == '0) begin
               stride_in = ADDR_BITS'(1);
               base_in   = '0;
               wrap_in   = '0;
               oob_in    = 1'b0;
               empty_in  = 1'b0;
            end else begin
               stride_in = stride_ff * ADDR_BITS'(prev_de_ff);
            end
            state_in = wiag_pkg::ST_ACCUM;
         end
         wiag_pkg::ST_ACCUM: begin
            prev_de_in = dest_ext[dim_ff];
            if (used[dim_ff]) begin
               base_in  = base_ff + origin_term;
               wrap_in  = wrap_ff + wrap_term;
               oob_in   = oob_ff | (reach > {1'b0, dest_ext[dim_ff]});
               empty_in = empty_ff | (se_cur == '0);
            end
            if (dim_ff == LAST_DIM) begin
               state_in = wiag_pkg::ST_IDLE;
               load_in  = 1'b1;
            end else begin
               dim_in   = dim_ff + DIM_IDX_BITS'(1);
               state_in = wiag_pkg::ST_STRIDE;
            end
         end
         default: begin
            state_in = wiag_pkg::ST_STRIDE;
            dim_in   = '0;
         end
      endcase

      // restart the pass on any register write
      if (start) begin
         state_in = wiag_pkg::ST_STRIDE;
         dim_in   = '0;
         load_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wiag_pkg::ST_STRIDE;
         dim_ff   <= '0;
         load_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         dim_ff   <= dim_in;
         load_ff  <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      stride_ff  <= stride_in;
      prev_de_ff <= prev_de_in;
      base_ff    <= base_in;
      wrap_ff    <= wrap_in;
      oob_ff     <= oob_in;
      empty_ff   <= empty_in;
      if (state_ff == wiag_pkg::ST_ACCUM) begin
         delta_ff[dim_ff] <= delta_in;
      end
   end

   always_comb begin
      status.busy  = (state_ff != wiag_pkg::ST_IDLE) || load_ff;
      status.load  = load_ff;
      status.oob   = oob_ff;
      status.empty = empty_ff;
   end

   assign base_addr = base_ff;

   generate
      for (genvar d = 0; d < MAX_DIMS; d++) begin : g_delta
         assign delta[d] = delta_ff[d];
      end
   endgenerate

   // Load follows in the cycle after the final accumulate step unless a write restarts
   a_load_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wiag_pkg::ST_ACCUM && dim_ff == LAST_DIM && !start) |=> load_ff)
      else $error("setup load missing after last dimension");

   // The pass always moves from a stride step to an accumulate step unless a write restarts it
   a_stride_then_accum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wiag_pkg::ST_STRIDE && !start) |=> (state_ff == wiag_pkg::ST_ACCUM))
      else $error("setup sequencer skipped accumulate step");

endmodule

/* design/wiag_walk.sv */
module wiag_walk #(
   parameter int unsigned MAX_DIMS    = 4,
   parameter int unsigned EXTENT_BITS = 16,
   parameter int unsigned ADDR_BITS   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  wiag_pkg::setup_status_type     status,
   input  logic                           advance,
   input  logic                           used    [MAX_DIMS],
   input  logic [EXTENT_BITS-1:0]         src_ext [MAX_DIMS],
   input  logic [ADDR_BITS-1:0]           base_addr,
   input  logic [ADDR_BITS-1:0]           delta   [MAX_DIMS],
   output logic [ADDR_BITS-1:0]           cur_addr,
   output logic                           cur_last
);

   logic [EXTENT_BITS-1:0] index_ff [MAX_DIMS];
   logic [EXTENT_BITS-1:0] index_in [MAX_DIMS];
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;

   logic                   at_end   [MAX_DIMS];
   logic                   carry    [MAX_DIMS+1];
   logic [ADDR_BITS-1:0]   step;
   logic                   wrap_all;

   // Carry chain over the dimensions, dimension zero first
   always_comb begin
      carry[0] = 1'b1;
      step     = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         at_end[d] = !used[d] ||
            (({1'b0, index_ff[d]} + (EXTENT_BITS+1)'(1)) >= {1'b0, src_ext[d]});
         carry[d+1] = carry[d] && at_end[d];
         if (!used[d] || (carry[d] && at_end[d])) begin
            index_in[d] = '0;
         end else if (carry[d]) begin
            index_in[d] = index_ff[d] + EXTENT_BITS'(1);
         end else begin
            index_in[d] = index_ff[d];
         end
         // exactly one dimension takes the increment unless all wrap
         if (carry[d] && !at_end[d]) begin
            step = step | delta[d];
         end
      end
      wrap_all = carry[MAX_DIMS];
      addr_in  = wrap_all ? base_addr : (addr_ff + step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            index_ff[d] <= '0;
         end
      end else if (status.load) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            index_ff[d] <= '0;
         end
      end else if (advance) begin
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.load) begin
         addr_ff <= base_addr;
      end else if (advance) begin
         addr_ff <= addr_in;
      end
   end

   assign cur_addr = addr_ff;
   assign cur_last = wrap_all;

   // No pixel moves the walk while the setup tables are being rebuilt
   a_no_advance_busy: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !advance)
      else $error("walk advanced during setup");

   // A last pixel returns the walk to the base address
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && wrap_all && !status.load) |=> (addr_ff == $past(base_addr)))
      else $error("walk did not restart at base address");

endmodule

/* design/wiag_out_fifo.sv */
module wiag_out_fifo #(
   parameter int unsigned WIDTH = 98
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             not_full,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   // Two entries let a new transfer in while the previous result waits
   always_comb begin
      pop       = out_valid && out_ready;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign not_full  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem[rd_ptr_ff];

   // Occupancy never exceeds the two entries
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("output queue count out of range");

   // Nothing is pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("output queue overflow");

   // A push without a pop adds exactly one entry
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("output queue count did not follow push");

endmodule

/* design/nd_window_insert_address_gen.sv */
// Channel | Direction | Ports                               | Transfer
// req     | in        | req_pixel_value                     | req_valid & req_ready
// rsp     | out       | rsp_dest_address, rsp_pixel_out,    | rsp_valid & rsp_ready
//         |           | rsp_write_enable, rsp_last_pixel,   |
//         |           | rsp_out_of_bounds                   |
// csr     | in/out    | APB: psel, penable, pwrite, paddr,  | psel & penable & pwrite
//         |           | pwdata, prdata, pready              |
//
// One pixel per cycle while req_ready is high; its result is queued at the transfer and offered in order.
// Address per pixel is one add of a precomputed per-dimension delta to the running address.
// After reset and after every register write the setup sequencer rebuilds strides, base
// and deltas, a stride and an accumulate step per dimension, then a load; req_ready stays low.
// Reset is synchronous; it restores the registers and starts the setup pass.
// A two-entry output queue keeps req_ready off the rsp_ready path; stalls on rsp hold it.
module nd_window_insert_address_gen #(
   parameter int unsigned MAX_DIMS    = 4,
   parameter int unsigned EXTENT_BITS = 16,
   parameter int unsigned PIXEL_BITS  = 32,
   parameter int unsigned ADDR_BITS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [PIXEL_BITS-1:0]               req_pixel_value,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ADDR_BITS-1:0]                rsp_dest_address,
   output logic [PIXEL_BITS-1:0]               rsp_pixel_out,
   output logic                                rsp_write_enable,
   output logic                                rsp_last_pixel,
   output logic                                rsp_out_of_bounds,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wiag_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [wiag_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [wiag_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned RESULT_BITS = ADDR_BITS + PIXEL_BITS + 3;

   logic [wiag_pkg::NUM_DIMS_BITS-1:0] num_dims_ff;
   logic [wiag_pkg::CFG_BITS-1:0]      dest_extents_ff;
   logic [wiag_pkg::CFG_BITS-1:0]      src_extents_ff;
   logic [wiag_pkg::CFG_BITS-1:0]      insert_origin_ff;

   wiag_pkg::reg_index_type    csr_index;
   logic                       csr_write;

   logic                       used     [MAX_DIMS];
   logic [EXTENT_BITS-1:0]     dest_ext [MAX_DIMS];
   logic [EXTENT_BITS-1:0]     src_ext  [MAX_DIMS];
   logic [EXTENT_BITS-1:0]     origin   [MAX_DIMS];

   wiag_pkg::setup_status_type status;
   logic [ADDR_BITS-1:0]       base_addr;
   logic [ADDR_BITS-1:0]       delta [MAX_DIMS];
   logic [ADDR_BITS-1:0]       cur_addr;
   logic                       cur_last;

   logic                       fifo_not_full;
   logic                       req_xfer;
   logic                       window_ok;
   logic [RESULT_BITS-1:0]     result;
   logic [RESULT_BITS-1:0]     rsp_data;

   // Register file write: setup and access phases, pready tied high
   assign csr_pready = 1'b1;
   assign csr_index  = wiag_pkg::reg_index_type'(csr_paddr[4:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff      <= wiag_pkg::NUM_DIMS_RESET;
         dest_extents_ff  <= '0;
         src_extents_ff   <= '0;
         insert_origin_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            wiag_pkg::REG_NUM_DIMS:
               num_dims_ff <= csr_pwdata[wiag_pkg::NUM_DIMS_BITS-1:0];
            wiag_pkg::REG_DEST_EXTENTS:  dest_extents_ff  <= csr_pwdata;
            wiag_pkg::REG_SRC_EXTENTS:   src_extents_ff   <= csr_pwdata;
            wiag_pkg::REG_INSERT_ORIGIN: insert_origin_ff <= csr_pwdata;
            default: num_dims_ff <= num_dims_ff;
         endcase
      end
   end

   // Register read back
   always_comb begin
      case (csr_index)
         wiag_pkg::REG_NUM_DIMS:
            csr_prdata = wiag_pkg::CSR_DATA_BITS'(num_dims_ff);
         wiag_pkg::REG_DEST_EXTENTS:  csr_prdata = dest_extents_ff;
         wiag_pkg::REG_SRC_EXTENTS:   csr_prdata = src_extents_ff;
         wiag_pkg::REG_INSERT_ORIGIN: csr_prdata = insert_origin_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   // Unpack per-dimension fields; a field past the 64-bit register reads zero.
   // Dimension zero is always used; a count above MAX_DIMS caps naturally.
   generate
      for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
         if (d == 0) begin : g_first
            assign used[d] = 1'b1;
         end else begin : g_rest
            assign used[d] = (num_dims_ff > wiag_pkg::NUM_DIMS_BITS'(d));
         end
         if ((d + 1) * EXTENT_BITS <= wiag_pkg::CFG_BITS) begin : g_fit
            assign dest_ext[d] = dest_extents_ff[d*EXTENT_BITS +: EXTENT_BITS];
            assign src_ext[d]  = src_extents_ff[d*EXTENT_BITS +: EXTENT_BITS];
            assign origin[d]   = insert_origin_ff[d*EXTENT_BITS +: EXTENT_BITS];
         end else begin : g_zero
            assign dest_ext[d] = '0;
            assign src_ext[d]  = '0;
            assign origin[d]   = '0;
         end
      end
   endgenerate

   wiag_setup #(
      .MAX_DIMS    (MAX_DIMS),
      .EXTENT_BITS (EXTENT_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .start     (csr_write),
      .used      (used),
      .dest_ext  (dest_ext),
      .src_ext   (src_ext),
      .origin    (origin),
      .status    (status),
      .base_addr (base_addr),
      .delta     (delta)
   );

   // Accept while the tables are ready and the output queue has room
   assign req_ready = fifo_not_full && !status.busy;
   assign req_xfer  = req_valid && req_ready;

   wiag_walk #(
      .MAX_DIMS    (MAX_DIMS),
      .EXTENT_BITS (EXTENT_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .advance   (req_xfer),
      .used      (used),
      .src_ext   (src_ext),
      .base_addr (base_addr),
      .delta     (delta),
      .cur_addr  (cur_addr),
      .cur_last  (cur_last)
   );

   // Suppress the write and zero the address for an invalid window
   assign window_ok = !status.oob && !status.empty;
   assign result = {(window_ok ? cur_addr : {ADDR_BITS{1'b0}}),
                    req_pixel_value, window_ok, cur_last, status.oob};

   wiag_out_fifo #(
      .WIDTH (RESULT_BITS)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (result),
      .not_full  (fifo_not_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_dest_address  = rsp_data[RESULT_BITS-1 -: ADDR_BITS];
   assign rsp_pixel_out     = rsp_data[PIXEL_BITS+2:3];
   assign rsp_write_enable  = rsp_data[2];
   assign rsp_last_pixel    = rsp_data[1];
   assign rsp_out_of_bounds = rsp_data[0];

endmodule
